@@ design/xcfr_pkg.sv @@
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies; used by every module of the block.
package xcfr_pkg;

   // Item opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BADSUM  = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // Configuration port
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned TIMEOUT_WIDTH  = 16;
   localparam logic        REG_TIMEOUT    = 1'b0;   // register index, paddr[2]
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

   localparam int unsigned TICK_COUNTER_WIDTH_DEFAULT = 16;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] data_byte;
      logic [7:0] frame_type;
      logic [7:0] command_type;
      logic [7:0] payload_length;
      logic       last_of_frame;
   } rsp_type;

   // Result produced by the parser for the item accepted this cycle
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage

@@ design/xcfr_csr.sv @@
// Configuration register file: byte timeout limit behind an APB-style port.
// Depends on xcfr_pkg.
module xcfr_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [xcfr_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [xcfr_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [xcfr_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output logic [xcfr_pkg::TIMEOUT_WIDTH-1:0]     timeout_ticks
);

   logic [xcfr_pkg::TIMEOUT_WIDTH-1:0] timeout_ff, timeout_in;
   logic                               hit_timeout;

   // low two address bits select a byte lane and are ignored
   assign hit_timeout = (csr_paddr[2] == xcfr_pkg::REG_TIMEOUT);

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_timeout) begin
         timeout_in = csr_pwdata[xcfr_pkg::TIMEOUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= xcfr_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign csr_pready    = 1'b1;
   assign csr_prdata    = hit_timeout ?
                          xcfr_pkg::CSR_DATA_WIDTH'(timeout_ff) : '0;
   assign timeout_ticks = timeout_ff;

endmodule

@@ design/xcfr_parser.sv @@
// Frame state machine: holds frame fields, running XOR and inter-byte wait
// counter, and forms the result for each accepted request. Depends on xcfr_pkg.
module xcfr_parser #(
   parameter int unsigned TICK_COUNTER_WIDTH = xcfr_pkg::TICK_COUNTER_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  xcfr_pkg::req_type                  item,
   input  logic [xcfr_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks,
   output xcfr_pkg::emit_type                 emit
);

   localparam int unsigned CmpWidth = (TICK_COUNTER_WIDTH > xcfr_pkg::TIMEOUT_WIDTH) ?
                                      TICK_COUNTER_WIDTH : xcfr_pkg::TIMEOUT_WIDTH;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_NUMBER  = 3'd1,
      PH_COMMAND = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [7:0]                      type_ff, type_in;
   logic [7:0]                      command_ff, command_in;
   logic [7:0]                      length_ff, length_in;
   logic [7:0]                      left_ff, left_in;
   logic [7:0]                      xor_ff, xor_in;
   logic [TICK_COUNTER_WIDTH-1:0]   wait_ff, wait_in;
   logic [TICK_COUNTER_WIDTH-1:0]   wait_inc;
   logic                            timed_out;
   logic [7:0]                      xor_final;
   logic [7:0]                      left_dec;

   assign wait_inc  = (wait_ff != {TICK_COUNTER_WIDTH{1'b1}}) ?
                      wait_ff + TICK_COUNTER_WIDTH'(1) : wait_ff;
   assign timed_out = CmpWidth'(wait_inc) > CmpWidth'(timeout_ticks);
   assign xor_final = xor_ff ^ item.rx_byte;
   assign left_dec  = left_ff - 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      command_in = command_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      xor_in     = xor_ff;
      wait_in    = wait_ff;

      emit                     = '0;
      emit.data.frame_type     = type_ff;
      emit.data.command_type   = command_ff;
      emit.data.payload_length = length_ff;

      if (accept) begin
         if (item.opcode == xcfr_pkg::OP_TICK) begin
            // ticks only count inside a frame; unused codes act as idle
            if (phase_ff != PH_IDLE && phase_ff <= PH_CHECK) begin
               wait_in = wait_inc;
               if (timed_out) begin
                  phase_in                = PH_IDLE;
                  wait_in                 = '0;
                  emit.valid              = 1'b1;
                  emit.data.result_kind   = xcfr_pkg::KIND_TIMEOUT;
                  emit.data.last_of_frame = 1'b1;
               end
            end
         end else begin
            wait_in = '0;
            unique case (phase_ff)
               PH_NUMBER: begin
                  phase_in = PH_COMMAND;
               end
               PH_COMMAND: begin
                  command_in = item.rx_byte;
                  xor_in     = xor_final;
                  phase_in   = PH_LENGTH;
               end
               PH_LENGTH: begin
                  length_in = item.rx_byte;
                  left_in   = item.rx_byte;
                  xor_in    = xor_final;
                  phase_in  = (item.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  xor_in                = xor_final;
                  left_in               = left_dec;
                  if (left_dec == 8'd0) begin
                     phase_in = PH_CHECK;
                  end
                  emit.valid            = 1'b1;
                  emit.data.result_kind = xcfr_pkg::KIND_DATA;
                  emit.data.data_byte   = item.rx_byte;
               end
               PH_CHECK: begin
                  xor_in                  = xor_final;
                  phase_in                = PH_IDLE;
                  emit.valid              = 1'b1;
                  emit.data.result_kind   = (xor_final == 8'd0) ?
                                            xcfr_pkg::KIND_GOOD : xcfr_pkg::KIND_BADSUM;
                  emit.data.last_of_frame = 1'b1;
               end
               default: begin
                  // idle or unused code: this byte is the frame type
                  type_in    = item.rx_byte;
                  command_in = 8'd0;
                  length_in  = 8'd0;
                  left_in    = 8'd0;
                  xor_in     = item.rx_byte;
                  phase_in   = PH_NUMBER;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         type_ff    <= 8'd0;
         command_ff <= 8'd0;
         length_ff  <= 8'd0;
         left_ff    <= 8'd0;
         xor_ff     <= 8'd0;
         wait_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         type_ff    <= type_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         xor_ff     <= xor_in;
         wait_ff    <= wait_in;
      end
   end

endmodule

@@ design/xcfr_rsp_reg.sv @@
// Result register: holds one result until the consumer takes it and
// frees the request side while it drains. Depends on xcfr_pkg.
module xcfr_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  xcfr_pkg::emit_type emit,
   output logic               load_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output xcfr_pkg::rsp_type  rsp_data
);

   logic              valid_ff, valid_in;
   xcfr_pkg::rsp_type data_ff, data_in;

   assign load_ok = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (accept && emit.valid) begin
         valid_in = 1'b1;
         data_in  = emit.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ design/xor_checked_frame_receiver.sv @@
// XOR-checked frame receiver: top level. Depends on xcfr_pkg, xcfr_csr,
// xcfr_parser and xcfr_rsp_reg.
//
// Takes one request per cycle, each either a received byte or a time tick,
// and parses frames of the form type, number, command, length, payload,
// check byte. Every payload byte comes out as a result at once; the check
// byte yields frame good (XOR of all bytes but the frame number is zero) or
// checksum error; too many ticks between bytes of a frame abort it with a
// timeout result. The frame state updates at the accepting edge and any
// result lands in a single result register, so a result shows in the cycle
// after its request is taken; throughput is one request per cycle as long
// as results are taken. req_ready drops only while a result is held and
// rsp_ready is low. byte_timeout_ticks (register 0, byte address 0, reset
// 1000) should be changed only while the block is idle.
module xor_checked_frame_receiver #(
   parameter int unsigned TICK_COUNTER_WIDTH = xcfr_pkg::TICK_COUNTER_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  xcfr_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output xcfr_pkg::rsp_type                   rsp_data,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [xcfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [xcfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [xcfr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   logic [xcfr_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks;
   logic                               accept;
   logic                               load_ok;
   xcfr_pkg::emit_type                 emit;

   // a request is taken whenever the result register can absorb its result
   assign req_ready = load_ok;
   assign accept    = req_valid && load_ok;

   xcfr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_ticks (timeout_ticks)
   );

   // frame state machine; result forms combinationally from the request
   xcfr_parser #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item          (req_data),
      .timeout_ticks (timeout_ticks),
      .emit          (emit)
   );

   // result register decouples the consumer from the parser
   xcfr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .emit      (emit),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/xcfr_checker.sv @@
// Checker for the XOR-checked frame receiver: watches the request, result and
// configuration ports, predicts each frame result and compares it in order, and
// checks timeout register reads. Depends on xcfr_pkg.
module xcfr_checker
   import xcfr_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = TICK_COUNTER_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   input  logic                      csr_pready,
   output int                        fail_count,
   output int                        results_pending
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_NUMBER, PH_COMMAND, PH_LENGTH, PH_PAYLOAD, PH_CHECK
   } frame_phase_e;

   frame_phase_e             phase;
   logic [7:0]               frame_type_q;
   logic [7:0]               command_q;
   logic [7:0]               length_q;
   logic [7:0]               remaining_q;
   logic [7:0]               xor_q;
   logic [COUNTER_WIDTH-1:0] tick_count_q;
   logic [TIMEOUT_WIDTH-1:0] limit_q;
   rsp_type                  pending_frame_results[$];
   int                       failures = 0;

   assign fail_count = failures;

   function automatic void flag_failure(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic string describe(rsp_type r);
      return $sformatf("kind %0d data %02h type %02h cmd %02h len %02h last %0b",
                       r.result_kind, r.data_byte, r.frame_type, r.command_type,
                       r.payload_length, r.last_of_frame);
   endfunction

   // Status of the frame in progress; payload results patch data and last.
   function automatic rsp_type frame_status(logic [1:0] kind);
      rsp_type r;
      r.result_kind    = kind;
      r.data_byte      = '0;
      r.frame_type     = frame_type_q;
      r.command_type   = command_q;
      r.payload_length = length_q;
      r.last_of_frame  = 1'b1;
      return r;
   endfunction

   function automatic bit next_frame_result(input req_type item, output rsp_type res);
      logic [7:0] b;
      b   = item.rx_byte;
      res = '0;
      if (item.opcode == OP_TICK) begin
         if (phase == PH_IDLE) begin
            return 1'b0;
         end
         if (tick_count_q != '1) begin
            tick_count_q++;
         end
         if (tick_count_q > limit_q) begin
            res          = frame_status(KIND_TIMEOUT);
            phase        = PH_IDLE;
            tick_count_q = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      tick_count_q = '0;
      case (phase)
         PH_IDLE: begin
            frame_type_q = b;
            command_q    = '0;
            length_q     = '0;
            remaining_q  = '0;
            xor_q        = b;
            phase        = PH_NUMBER;
         end
         PH_NUMBER: phase = PH_COMMAND;
         PH_COMMAND: begin
            command_q = b;
            xor_q     ^= b;
            phase     = PH_LENGTH;
         end
         PH_LENGTH: begin
            length_q    = b;
            remaining_q = b;
            xor_q       ^= b;
            phase       = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            xor_q ^= b;
            remaining_q--;
            if (remaining_q == 8'd0) begin
               phase = PH_CHECK;
            end
            res               = frame_status(KIND_DATA);
            res.data_byte     = b;
            res.last_of_frame = 1'b0;
            return 1'b1;
         end
         default: begin
            xor_q ^= b;
            res   = frame_status((xor_q == 8'd0) ? KIND_GOOD : KIND_BADSUM);
            phase = PH_IDLE;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type predicted;
      rsp_type oldest;
      string   bad_fields;
      if (reset) begin
         phase        = PH_IDLE;
         frame_type_q = '0;
         command_q    = '0;
         length_q     = '0;
         remaining_q  = '0;
         xor_q        = '0;
         tick_count_q = '0;
         limit_q      = TIMEOUT_RESET;
         pending_frame_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_TIMEOUT) begin
            if (csr_pwrite) begin
               limit_q = csr_pwdata[TIMEOUT_WIDTH-1:0];
            end else if (csr_prdata !== CSR_DATA_WIDTH'(limit_q)) begin
               flag_failure($sformatf("timeout register read %08h, expected %08h",
                                      csr_prdata, CSR_DATA_WIDTH'(limit_q)));
            end
         end
         if (req_valid && req_ready) begin
            if (next_frame_result(req_data, predicted)) begin
               pending_frame_results.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_frame_results.size() == 0) begin
               flag_failure({"unexpected result: ", describe(rsp_data)});
            end else begin
               oldest     = pending_frame_results.pop_front();
               bad_fields = "";
               if (rsp_data.result_kind !== oldest.result_kind)
                  bad_fields = {bad_fields, " result_kind"};
               if (rsp_data.data_byte !== oldest.data_byte)
                  bad_fields = {bad_fields, " data_byte"};
               if (rsp_data.frame_type !== oldest.frame_type)
                  bad_fields = {bad_fields, " frame_type"};
               if (rsp_data.command_type !== oldest.command_type)
                  bad_fields = {bad_fields, " command_type"};
               if (rsp_data.payload_length !== oldest.payload_length)
                  bad_fields = {bad_fields, " payload_length"};
               if (rsp_data.last_of_frame !== oldest.last_of_frame)
                  bad_fields = {bad_fields, " last_of_frame"};
               if (bad_fields != "") begin
                  flag_failure($sformatf("result mismatch in%s: expected %s, got %s",
                                         bad_fields, describe(oldest), describe(rsp_data)));
               end
            end
         end
      end
      results_pending <= pending_frame_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the XOR-checked frame receiver: clock, reset, request and
// configuration stimulus, result back-pressure, watchdog and verdict.
// Depends on xcfr_pkg, xor_checked_frame_receiver and xcfr_checker.
module tb_top;
   import xcfr_pkg::*;

   localparam int unsigned COUNTER_WIDTH  = TICK_COUNTER_WIDTH_DEFAULT;
   localparam int unsigned TIMEOUT_INDEX  = int'(REG_TIMEOUT);
   localparam int unsigned UNMAPPED_INDEX = 1;     // paddr 4, no register behind it
   localparam int          STALL_LIMIT    = 2000;  // cycles with no handshake at all

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_type                   req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int results_pending;

   // Sender bookkeeping: burst length left, whether valid is currently driven
   // high, and how many counted requests have gone in (stop criterion only).
   int          burst_left       = 0;
   bit          req_driving      = 1'b0;
   int          requests_counted = 0;
   int unsigned timeout_now      = TIMEOUT_RESET;

   // Receiver back-pressure state.
   int ready_mode  = 0;
   int ready_span  = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   xor_checked_frame_receiver #(
      .TICK_COUNTER_WIDTH(COUNTER_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   xcfr_checker #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .results_pending(results_pending)
   );

   // Receiver: switches between always ready, coin-flip ready and mostly
   // stalled, each for a random span, so stalls land on every phase.
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_span <= $urandom_range(8, 96);
      end else begin
         ready_span <= ready_span - 1;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Watchdog: a run that stops moving is a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request through the handshake. Bursts end with a gap, so valid is
   // never lowered and raised in the same step.
   task automatic send_request(input logic op, input logic [7:0] value, input bit counted);
      if (burst_left == 0) begin
         if (req_driving) begin
            req_valid <= 1'b0;
         end
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_driving  = 1'b1;
      req_data    <= '{opcode: op, rx_byte: value};
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (counted) begin
         requests_counted++;
      end
   endtask

   // Lower valid, then wait until every predicted result has been taken so the
   // block is quiet before touching its register.
   task automatic settle();
      if (req_driving) begin
         req_valid <= 1'b0;
      end
      req_driving = 1'b0;
      burst_left  = 0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB setup + access; pready is honored even though it is tied high.
   task automatic csr_access(input bit write, input int unsigned index,
                             input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_WIDTH'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the byte timeout with junk in the unused upper half, read it back.
   task automatic set_timeout(input int unsigned value);
      settle();
      csr_access(1'b1, TIMEOUT_INDEX, {16'($urandom), 16'(value)});
      csr_access(1'b0, TIMEOUT_INDEX, '0);
      timeout_now = value;
   endtask

   // Whole frame with a correct or spoiled check byte. Ticks may fall between
   // bytes; with cut >= 0 the frame stops after that byte and, where the
   // limit is small, enough ticks follow to force the timeout.
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] number,
                             input logic [7:0] cmd, input logic [7:0] len,
                             input bit corrupt, input int cut, input int tick_odds);
      logic [7:0] frame_bytes[$];
      logic [7:0] check_sum;
      logic [7:0] payload;
      int         wait_ticks;
      frame_bytes = {ftype, number, cmd, len};
      check_sum   = ftype ^ cmd ^ len;     // frame number stays out of the sum
      for (int i = 0; i < len; i++) begin
         payload   = 8'($urandom);
         check_sum ^= payload;
         frame_bytes.push_back(payload);
      end
      if (corrupt) begin
         check_sum ^= 8'($urandom_range(1, 255));
      end
      frame_bytes.push_back(check_sum);
      foreach (frame_bytes[i]) begin
         send_request(OP_BYTE, frame_bytes[i], 1'b1);
         if (i == cut) begin
            if (timeout_now <= 64) begin
               repeat (timeout_now + 1) send_request(OP_TICK, 8'($urandom), 1'b1);
            end
            return;
         end
         if (i < frame_bytes.size() - 1 && $urandom_range(1, 100) <= tick_odds) begin
            // small limits: land on both sides of the boundary
            wait_ticks = (timeout_now <= 8) ? $urandom_range(1, timeout_now + 2)
                                            : $urandom_range(1, 4);
            repeat (wait_ticks) send_request(OP_TICK, 8'($urandom), 1'b1);
         end
      end
   endtask

   // Mostly well-formed frames with random content; the rest truncated
   // frames and raw noise that can start frames anywhere.
   task automatic random_traffic(input int quota);
      int         stop_at;
      int         pick;
      logic [7:0] len;
      stop_at = requests_counted + quota;
      while (requests_counted < stop_at) begin
         pick = $urandom_range(1, 100);
         len  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 40))
                                            : 8'($urandom_range(0, 8));
         if (pick <= 80) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), len,
                       ($urandom_range(0, 3) == 0), -1, 25);
            if ($urandom_range(0, 4) == 0) begin
               send_request(OP_TICK, 8'($urandom), 1'b0);   // idle tick, ignored
            end
         end else if (pick <= 90) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), len, 1'b0,
                       $urandom_range(0, len + 4), 10);
         end else begin
            repeat ($urandom_range(1, 6)) send_request(1'($urandom), 8'($urandom), 1'b1);
         end
      end
   endtask

   initial begin : stimulus
      // zero-length good frame, type and command all ones, then a frame with
      // type and command zero, two extreme payload bytes, spoiled check byte
      logic [7:0]  opening_frames[12] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00,
                                          8'h00, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00, 8'hFC};
      int unsigned timeout_plan[7]    = '{0, 1, 2, 5, 8, 65535, 300};
      timeout_plan[6] = $urandom_range(9, 65534);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset value of the limit, idle tick, both opening frames.
      csr_access(1'b0, TIMEOUT_INDEX, '0);
      send_request(OP_TICK, 8'hFF, 1'b1);
      foreach (opening_frames[i]) send_request(OP_BYTE, opening_frames[i], 1'b1);

      // Unmapped register write must leave the limit alone.
      set_timeout(3);
      csr_access(1'b1, UNMAPPED_INDEX, 32'hFFFF_0007);
      csr_access(1'b0, TIMEOUT_INDEX, '0);

      // Limit of 3: three ticks survive, four abort before the command byte,
      // and the tick after the abort is idle.
      send_request(OP_BYTE, 8'h11, 1'b1);
      repeat (3) send_request(OP_TICK, 8'h00, 1'b1);
      send_request(OP_BYTE, 8'h22, 1'b1);
      repeat (4) send_request(OP_TICK, 8'hFF, 1'b1);
      send_request(OP_TICK, 8'h00, 1'b1);

      // Limit of 0: the first tick inside a frame aborts it.
      set_timeout(0);
      send_request(OP_BYTE, 8'h80, 1'b1);
      send_request(OP_TICK, 8'h01, 1'b1);

      // Random phases across limits, one maximum-length frame included.
      foreach (timeout_plan[p]) begin
         set_timeout(timeout_plan[p]);
         if (timeout_plan[p] == 65535) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd255, 1'b0, -1, 10);
         end
         random_traffic(140);
      end

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/xcfr_pkg.sv
design/xcfr_csr.sv
design/xcfr_parser.sv
design/xcfr_rsp_reg.sv
design/xor_checked_frame_receiver.sv
dv/xcfr_checker.sv
dv/tb_top.sv
